>>> sv/lgst_pkg.sv
// ----------------------------------------------------------------------------
// lgst_pkg
// Shared types and constants for the two-gate speed timer.
// ----------------------------------------------------------------------------
`default_nettype none

package lgst_pkg;

  localparam int unsigned DIST_BITS   = 20;
  localparam int unsigned WHOLE_BITS  = 17;
  localparam int unsigned TENTH_BITS  = 4;
  localparam int unsigned SHOWN_BITS  = 16;

  localparam logic [DIST_BITS-1:0] DIST_RESET = 20'd101600;

  // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every x below 2^22
  localparam logic [DIST_BITS-1:0] RECIP_TEN   = 20'd838861;
  localparam int unsigned          RECIP_SHIFT = 23;
  localparam logic [3:0]           TENTH_DIV   = 4'd10;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_GATE = 1'b1;

  localparam logic GATE_BLOCKED = 1'b0;

  typedef struct packed {
    logic cmd;
    logic gate_one_level;
    logic gate_two_level;
  } in_word_t;

  typedef struct packed {
    logic                  timing_active;
    logic                  measure_done;
    logic                  divide_error;
    logic [SHOWN_BITS-1:0] elapsed_ms;
    logic [DIST_BITS-1:0]  speed_raw;
    logic [WHOLE_BITS-1:0] speed_whole;
    logic [TENTH_BITS-1:0] speed_tenth;
  } out_word_t;

endpackage

`default_nettype wire

>>> sv/light_gate_speed_timer_core.sv
// ----------------------------------------------------------------------------
// light_gate_speed_timer_core
// Two-gate speed trap: millisecond timing between gates and speed readout.
// ----------------------------------------------------------------------------
// Each input word is a millisecond tick or a gate change carrying both gate
// levels (0 = blocked); every input word yields exactly one output word. Gate
// one blocked while idle starts a measurement with a cleared count, ticks
// advance the count (saturating), and gate two blocked while timing ends it.
// The speed in tenths is distance / count, also split into whole
// units and tenths; a zero count flags divide_error and reports zero speed.
// A tick or a gate change that ends no measurement goes from accept straight
// to the write step and the output register; a word that ends a measurement
// with a nonzero count is accepted and starts the bit-serial divider (one
// quotient bit per cycle); the quotient is then captured, split by the
// divide-by-ten multiply and loaded into the output register. One word is in
// work at a time; in_stall is high until the result has moved into the
// output register, which holds it while out_stall is high. cfg_ready is
// always high; write the distance register only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module light_gate_speed_timer_core
  import lgst_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input words
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire in_word_t             in_word,
  // output words
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      out_word_t            out_word,
  // distance register write
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [DIST_BITS-1:0] cfg_data
);

  localparam int unsigned WIDE_BITS = (COUNT_BITS > SHOWN_BITS) ? COUNT_BITS : SHOWN_BITS;
  localparam int unsigned PROD_BITS = 2 * DIST_BITS;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIVIDE = 4'b0010,
    S_SCALE  = 4'b0100,
    S_WRITE  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Architectural state
  logic                  running;
  logic [COUNT_BITS-1:0] ms_count;
  logic [DIST_BITS-1:0]  distance;

  // Result under construction
  logic                  res_done;
  logic                  res_err;
  logic [SHOWN_BITS-1:0] res_shown;
  logic [DIST_BITS-1:0]  speed;
  logic [WHOLE_BITS-1:0] whole;

  // Next values on accept
  logic                  in_accept;
  logic                  running_next;
  logic [COUNT_BITS-1:0] count_next;
  logic                  done_next;
  logic                  err_next;
  logic [WIDE_BITS-1:0]  count_wide;
  logic [SHOWN_BITS-1:0] shown_next;

  // Divider link
  logic                  div_start;
  logic                  div_done;
  logic [DIST_BITS-1:0]  div_quo;

  logic [PROD_BITS-1:0]  recip_prod;
  logic [DIST_BITS-1:0]  whole_x10;
  logic [DIST_BITS-1:0]  tenth_full;
  logic                  out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid & ~in_stall;

  // Apply one event to the run flag and the count: start, then stop checks
  // run on the same gate change.
  always_comb begin
    running_next = running;
    count_next   = ms_count;
    done_next    = 1'b0;
    err_next     = 1'b0;
    if (in_word.cmd == CMD_TICK) begin
      if (running && (ms_count != '1)) begin
        count_next = ms_count + COUNT_BITS'(1);
      end
    end else begin
      if ((in_word.gate_one_level == GATE_BLOCKED) && !running) begin
        running_next = 1'b1;
        count_next   = '0;
      end
      if ((in_word.gate_two_level == GATE_BLOCKED) && running_next) begin
        running_next = 1'b0;
        done_next    = 1'b1;
        err_next     = (count_next == '0);
      end
    end
    // Saturate the shown count to its 16-bit field
    count_wide = WIDE_BITS'(count_next);
    shown_next = (count_wide > WIDE_BITS'(17'h0FFFF)) ? 16'hFFFF : count_wide[SHOWN_BITS-1:0];
  end

  // Divide only when a measurement ends with a nonzero count
  assign div_start = in_accept & done_next & ~err_next;

  // The final count sits in ms_count for the whole divide, since no new word
  // is accepted until the result is written out.
  lgst_divider #(
    .COUNT_BITS (COUNT_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (distance),
    .divisor  (ms_count),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Divide by ten through the reciprocal; remainder from the registered whole
  assign recip_prod = PROD_BITS'(speed) * PROD_BITS'(RECIP_TEN);
  assign whole_x10  = DIST_BITS'(whole) * DIST_BITS'(TENTH_DIV);
  assign tenth_full = speed - whole_x10;

  assign out_load = (state == S_WRITE) && (!out_valid || !out_stall);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = div_start ? S_DIVIDE : S_WRITE;
        end
      end
      S_DIVIDE: begin
        if (div_done) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      running   <= 1'b0;
      ms_count  <= '0;
      distance  <= DIST_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        distance <= cfg_data;
      end
      if (in_accept) begin
        running  <= running_next;
        ms_count <= count_next;
      end
      // Hold the output word until taken, refill it from the write step
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_done  <= done_next;
      res_err   <= err_next;
      res_shown <= shown_next;
      speed     <= '0;
      whole     <= '0;
    end
    if (state == S_DIVIDE && div_done) begin
      speed <= div_quo;
    end
    if (state == S_SCALE) begin
      whole <= recip_prod[RECIP_SHIFT +: WHOLE_BITS];
    end
    if (out_load) begin
      out_word.timing_active <= running;
      out_word.measure_done  <= res_done;
      out_word.divide_error  <= res_err;
      out_word.elapsed_ms    <= res_shown;
      out_word.speed_raw     <= speed;
      out_word.speed_whole   <= whole;
      out_word.speed_tenth   <= tenth_full[TENTH_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // An error word always closes a measurement and carries zero speed
  a_err_is_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.divide_error |->
      out_word.measure_done && (out_word.speed_raw == '0))
    else $error("divide_error without measure_done or with nonzero speed");

  // A finished measurement leaves the timer stopped
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.measure_done |-> !out_word.timing_active)
    else $error("measure_done while timing_active");

  // Whole and tenth recombine to the raw speed
  a_split_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.speed_tenth < TENTH_DIV) &&
      (DIST_BITS'(out_word.speed_whole) * DIST_BITS'(TENTH_DIV) +
       DIST_BITS'(out_word.speed_tenth) == out_word.speed_raw))
    else $error("speed split into whole and tenth is inconsistent");

  // The divider only finishes while the sequencer waits for it
  a_div_in_step: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVIDE))
    else $error("divider finished outside the divide step");

endmodule

`default_nettype wire

>>> sv/lgst_divider.sv
// ----------------------------------------------------------------------------
// lgst_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lgst_divider
  import lgst_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIST_BITS-1:0]  dividend,
  input  wire logic [COUNT_BITS-1:0] divisor,
  output      logic                  done,
  output      logic [DIST_BITS-1:0]  quotient
);

  localparam int unsigned STEP_BITS = $clog2(DIST_BITS);

  logic                  busy;
  logic [STEP_BITS-1:0]  step;
  logic [COUNT_BITS-1:0] rem;
  logic [DIST_BITS-1:0]  quo;

  logic [COUNT_BITS:0]   rem_shift;
  logic [COUNT_BITS:0]   diff;
  logic                  q_bit;
  logic [COUNT_BITS-1:0] rem_next;

  // Shift in the next dividend bit, try the subtract, keep it when no borrow.
  always_comb begin
    rem_shift = {rem, quo[DIST_BITS-1]};
    diff      = rem_shift - {1'b0, divisor};
    q_bit     = ~diff[COUNT_BITS];
    rem_next  = q_bit ? diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_BITS'(1);
        if (step == STEP_BITS'(DIST_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DIST_BITS-2:0], q_bit};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-gate speed timer core.
// ----------------------------------------------------------------------------
// A queue of pending input words feeds a clocked driver; each accepted word
// runs through a local timing/speed predictor that stores the expected
// readout. A clocked monitor compares every accepted output word field by
// field with the oldest stored readout. Stimulus starts with a short
// directed list under the reset distance, then random gate sequences under
// several distance settings (max, one, zero, random), with random idling on
// both channels and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lgst_pkg::*;

  localparam int unsigned  CNT_BITS     = 16;
  localparam longint unsigned CNT_MAX   = (64'd1 << CNT_BITS) - 1;
  localparam int unsigned  SETTLE       = 40;       // beyond the divide path
  localparam int unsigned  HOLD_CYCLES  = 400;
  localparam int unsigned  CYCLE_LIMIT  = 2_000_000;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  in_word_t             in_word    = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  out_word_t            out_word;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [DIST_BITS-1:0] cfg_data   = '0;

  // stimulus and scoreboard state
  in_word_t        pending_words[$];
  out_word_t       expected_readouts[$];
  int unsigned     queued_words;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     hold_requests;
  int unsigned     hold_served;
  int unsigned     hold_left;
  int unsigned     mismatch_count;
  longint unsigned cycle_count;

  // predictor state: distance register, run flag and millisecond count
  logic [DIST_BITS-1:0] dist_model;
  bit                   trap_running;
  longint unsigned      trap_count;

  light_gate_speed_timer_core #(
    .COUNT_BITS(CNT_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the trap state by one input word and build the readout it yields.
  function automatic out_word_t predict_readout(in_word_t w);
    out_word_t       r;
    longint unsigned spd;
    bit              done;
    bit              err;
    spd  = 0;
    done = 1'b0;
    err  = 1'b0;
    if (w.cmd == CMD_TICK) begin
      // ticks only count while timing, and stick at the top
      if (trap_running && trap_count < CNT_MAX) trap_count++;
    end else begin
      // gate one starts from idle; gate two may end on the same event
      if (w.gate_one_level == GATE_BLOCKED && !trap_running) begin
        trap_running = 1'b1;
        trap_count   = 0;
      end
      if (w.gate_two_level == GATE_BLOCKED && trap_running) begin
        trap_running = 1'b0;
        done         = 1'b1;
        if (trap_count == 0) err = 1'b1;
        else spd = longint'(dist_model) / trap_count;
      end
    end
    spd             = spd & 64'hF_FFFF;
    r.timing_active = trap_running;
    r.measure_done  = done;
    r.divide_error  = err;
    r.elapsed_ms    = (trap_count > 64'hFFFF) ? 16'hFFFF : trap_count[15:0];
    r.speed_raw     = spd[DIST_BITS-1:0];
    r.speed_whole   = WHOLE_BITS'(spd / 10);
    r.speed_tenth   = TENTH_BITS'(spd % 10);
    return r;
  endfunction

  // Drive input words: predict on accept, then offer the next word or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      trap_running  = 1'b0;
      trap_count    = 0;
    end else begin
      if (in_valid && !in_stall) expected_readouts.push_back(predict_readout(in_word));
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_word  <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the output channel: a requested long hold first, else random stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      hold_served  = 0;
      hold_left    = 0;
    end else if (hold_served != hold_requests) begin
      hold_served  = hold_requests;
      hold_left    = HOLD_CYCLES - 1;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Track the distance register on each accepted write.
  always @(posedge clk) begin
    if (rst) dist_model = DIST_RESET;
    else if (cfg_valid && cfg_ready) dist_model = cfg_data;
  end

  // Check every accepted output word against the oldest expected readout.
  always @(posedge clk) begin : check_readout
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_readouts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected output word %h at cycle %0d", out_word, cycle_count);
      end else begin
        want = expected_readouts.pop_front();
        if (out_word.timing_active !== want.timing_active ||
            out_word.measure_done  !== want.measure_done  ||
            out_word.divide_error  !== want.divide_error  ||
            out_word.elapsed_ms    !== want.elapsed_ms    ||
            out_word.speed_raw     !== want.speed_raw     ||
            out_word.speed_whole   !== want.speed_whole   ||
            out_word.speed_tenth   !== want.speed_tenth) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("readout mismatch at cycle %0d (dist %0d)", cycle_count, dist_model);
            $display("  expected act=%b done=%b err=%b ms=%0d raw=%0d whole=%0d tenth=%0d",
                     want.timing_active, want.measure_done, want.divide_error,
                     want.elapsed_ms, want.speed_raw, want.speed_whole, want.speed_tenth);
            $display("  actual   act=%b done=%b err=%b ms=%0d raw=%0d whole=%0d tenth=%0d",
                     out_word.timing_active, out_word.measure_done, out_word.divide_error,
                     out_word.elapsed_ms, out_word.speed_raw, out_word.speed_whole,
                     out_word.speed_tenth);
          end
        end
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_word(logic cmd, logic g1, logic g2);
    in_word_t w;
    w.cmd            = cmd;
    w.gate_one_level = g1;
    w.gate_two_level = g2;
    pending_words.push_back(w);
    queued_words++;
  endtask

  // Hold until every word is in and every readout checked, then settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_readouts.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_distance(logic [DIST_BITS-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly well-formed passes (start, ticks, stop) with random gate noise.
  task automatic queue_random_passes(int unsigned n);
    int unsigned target;
    int unsigned pick;
    int unsigned ticks;
    target = queued_words + n;
    while (queued_words < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        // start; now and then gate two is already blocked too
        push_word(CMD_GATE, GATE_BLOCKED, ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1);
        pick = $urandom_range(0, 99);
        if (pick < 10)      ticks = 0;
        else if (pick < 75) ticks = $urandom_range(1, 12);
        else if (pick < 98) ticks = $urandom_range(13, 150);
        else                ticks = $urandom_range(151, 600);
        for (int unsigned i = 0; i < ticks; i++) begin
          // gate bits ride along on ticks and must be ignored
          push_word(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 19) == 0)
            push_word(CMD_GATE, 1'($urandom_range(0, 1)), 1'b1);
        end
        push_word(CMD_GATE, 1'($urandom_range(0, 1)), GATE_BLOCKED);
      end else begin
        push_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    queued_words   = 0;
    send_idle_pct  = 32;
    recv_idle_pct  = 80;
    hold_requests  = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words under the reset distance.
    push_word(CMD_TICK, 1'b0, 1'b0);          // tick while idle: ignored
    push_word(CMD_GATE, 1'b1, 1'b1);          // both clear while idle
    push_word(CMD_GATE, 1'b1, 1'b0);          // gate two alone while idle
    push_word(CMD_GATE, 1'b0, 1'b0);          // both blocked: start and stop at once
    push_word(CMD_GATE, 1'b0, 1'b1);          // start, then stop with no ticks
    push_word(CMD_GATE, 1'b1, 1'b0);
    push_word(CMD_GATE, 1'b0, 1'b1);          // four-tick pass with a repeat of gate one
    repeat (3) push_word(CMD_TICK, 1'b1, 1'b1);
    push_word(CMD_GATE, 1'b0, 1'b1);
    push_word(CMD_TICK, 1'b0, 1'b1);
    push_word(CMD_GATE, 1'b0, 1'b0);
    push_word(CMD_GATE, 1'b0, 1'b1);          // single tick: full distance
    push_word(CMD_TICK, 1'b1, 1'b0);
    push_word(CMD_GATE, 1'b1, 1'b0);
    push_word(CMD_GATE, 1'b0, 1'b1);          // seven ticks: nonzero tenths
    repeat (7) push_word(CMD_TICK, 1'b0, 1'b0);
    push_word(CMD_GATE, 1'b1, 1'b0);
    wait_drained();

    // Largest distance.
    write_distance(20'hF_FFFF);
    queue_random_passes(180);
    wait_drained();

    // Swap idling: sender slow, receiver mostly ready.
    send_idle_pct = 80;
    recv_idle_pct = 32;
    write_distance(20'd1);
    queue_random_passes(180);
    wait_drained();

    // Zero distance: speeds read zero, with no error flag unless the count is zero.
    write_distance('0);
    queue_random_passes(60);
    wait_drained();

    // No idling; hold the output long enough to back up the input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_distance(DIST_BITS'($urandom_range(1, 20'hF_FFFF)));
    hold_requests++;
    queue_random_passes(220);
    wait_drained();

    if (mismatch_count == 0 && expected_readouts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lgst_pkg.sv
sv/lgst_divider.sv
sv/light_gate_speed_timer_core.sv
dv/tb_top.sv
